// File: rtl/signed_binary_to_decimal_ascii_assert.svh
// Assertion macros used by the top-level RTL file.
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_ASSERT_SVH

`ifndef SYNTHESIS

`define SBDA_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("sbda assertion failed");

`define SBDA_ASSERT_NXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("sbda assertion failed");

`else

`define SBDA_ASSERT_IMP(label, pre, post)

`define SBDA_ASSERT_NXT(label, pre, post)

`endif

`endif

// File: rtl/sbda_pkg.sv
`default_nettype none

package sbda_pkg;

  localparam int CHAR_W = 6;
  localparam int BITS_PER_STAGE = 4;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] ASCII_NINE = 6'd57;

  function automatic logic [3:0] bcd_adjust(input logic [3:0] d);
    return (d >= 4'd5) ? d + 4'd3 : d;
  endfunction

endpackage

`default_nettype wire

// File: rtl/sbda_sign.sv
`default_nettype none

module sbda_sign #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [VALUE_BITS-1:0] in_value,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_neg,
  output logic [VALUE_BITS-1:0]      out_mag
);

  logic                  valid_r;
  logic                  valid_nxt;
  logic                  neg_r;
  logic [VALUE_BITS-1:0] mag_r;
  logic                  load;

  assign in_ready  = !valid_r || out_ready;
  assign load      = in_valid && in_ready;
  assign valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // The magnitude is unsigned, so the most negative value wraps to its true size.
  always_ff @(posedge clk) begin
    if (load) begin
      neg_r <= in_value[VALUE_BITS-1];
      mag_r <= in_value[VALUE_BITS-1] ? (~in_value + VALUE_BITS'(1)) : in_value;
    end
  end

  assign out_valid = valid_r;
  assign out_neg   = neg_r;
  assign out_mag   = mag_r;

endmodule

`default_nettype wire

// File: rtl/sbda_dabble.sv
`default_nettype none

module sbda_dabble #(
  parameter int VALUE_BITS = 32,
  parameter int DIGITS     = 10,
  parameter int STEPS      = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_neg,
  input  wire logic [VALUE_BITS-1:0] in_mag,
  input  wire logic [4*DIGITS-1:0]   in_bcd,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_neg,
  output logic [VALUE_BITS-1:0]      out_mag,
  output logic [4*DIGITS-1:0]        out_bcd
);

  import sbda_pkg::*;

  localparam int BCD_W = 4 * DIGITS;

  logic                  valid_r;
  logic                  valid_nxt;
  logic                  neg_r;
  logic [VALUE_BITS-1:0] mag_r;
  logic [VALUE_BITS-1:0] mag_nxt;
  logic [BCD_W-1:0]      bcd_r;
  logic [BCD_W-1:0]      bcd_nxt;
  logic                  load;

  assign in_ready  = !valid_r || out_ready;
  assign load      = in_valid && in_ready;
  assign valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  // Shift-and-add-three, one magnitude bit per step.
  always_comb begin
    mag_nxt = in_mag;
    bcd_nxt = in_bcd;
    for (int s = 0; s < STEPS; s++) begin
      for (int d = 0; d < DIGITS; d++) begin
        bcd_nxt[4*d +: 4] = bcd_adjust(bcd_nxt[4*d +: 4]);
      end
      bcd_nxt = {bcd_nxt[BCD_W-2:0], mag_nxt[VALUE_BITS-1]};
      mag_nxt = {mag_nxt[VALUE_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      neg_r <= in_neg;
      mag_r <= mag_nxt;
      bcd_r <= bcd_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_neg   = neg_r;
  assign out_mag   = mag_r;
  assign out_bcd   = bcd_r;

endmodule

`default_nettype wire

// File: rtl/sbda_emit.sv
`default_nettype none

module sbda_emit #(
  parameter int DIGITS = 10
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   in_neg,
  input  wire logic [4*DIGITS-1:0]    in_bcd,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [sbda_pkg::CHAR_W-1:0] out_char,
  output logic                        out_last
);

  import sbda_pkg::*;

  localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  logic              busy_r;
  logic              busy_nxt;
  logic              minus_r;
  logic              minus_nxt;
  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  idx_nxt;
  logic [IDX_W-1:0]  top_idx;
  logic [4*DIGITS-1:0] bcd_r;
  logic              last_now;
  logic              take;
  logic              load;

  assign last_now = !minus_r && (idx_r == '0);
  assign take     = busy_r && out_ready;
  assign in_ready = !busy_r || (out_ready && last_now);
  assign load     = in_valid && in_ready;

  // Highest nonzero digit; zero itself prints as one digit.
  always_comb begin
    top_idx = '0;
    for (int d = 0; d < DIGITS; d++) begin
      if (in_bcd[4*d +: 4] != 4'd0) begin
        top_idx = IDX_W'(d);
      end
    end
  end

  always_comb begin
    busy_nxt  = busy_r;
    minus_nxt = minus_r;
    idx_nxt   = idx_r;
    if (load) begin
      busy_nxt  = 1'b1;
      minus_nxt = in_neg;
      idx_nxt   = top_idx;
    end else if (take) begin
      if (minus_r) begin
        minus_nxt = 1'b0;
      end else if (idx_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r - IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      minus_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      minus_r <= minus_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (load) begin
      bcd_r <= in_bcd;
    end
  end

  assign out_valid = busy_r;
  assign out_last  = last_now;
  assign out_char  = minus_r ? ASCII_MINUS
                             : ASCII_ZERO + {2'b00, bcd_r[4*idx_r +: 4]};

endmodule

`default_nettype wire

// File: rtl/signed_binary_to_decimal_ascii.sv
// Channel   Direction  tdata                        tuser  tlast
// in_       slave      value[VALUE_BITS-1:0]        -      -
// out_      master     character[5:0]               -      last
//
// A request passes a sign stage, ceil(VALUE_BITS/4) conversion stages of up to four
// shift-and-add-three steps each, and a character serializer.
// Each number leaves as 1 to 11 characters at one per cycle while out_tready is high
// (up to 20 when VALUE_BITS is 64), so the serializer sets the sustained rate.
// Reset empties every stage; an output stall backs up the stages without loss.
`default_nettype none

`include "signed_binary_to_decimal_ascii_assert.svh"

module signed_binary_to_decimal_ascii #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [((VALUE_BITS+7)/8)*8-1:0]     in_tdata,  // value
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [7:0]                               out_tdata, // character
  output logic                                     out_tlast
);

  import sbda_pkg::*;

  localparam int DIGITS = (VALUE_BITS * 3) / 10 + 1;
  localparam int NST    = (VALUE_BITS + BITS_PER_STAGE - 1) / BITS_PER_STAGE;

  logic                  vld [NST+1];
  logic                  rdy [NST+1];
  logic                  neg [NST+1];
  logic [VALUE_BITS-1:0] mag [NST+1];
  logic [4*DIGITS-1:0]   bcd [NST+1];
  logic [CHAR_W-1:0]     character;

  sbda_sign #(
    .VALUE_BITS(VALUE_BITS)
  ) u_sign (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_value (in_tdata[VALUE_BITS-1:0]),
    .out_valid(vld[0]),
    .out_ready(rdy[0]),
    .out_neg  (neg[0]),
    .out_mag  (mag[0])
  );

  assign bcd[0] = '0;

  for (genvar i = 0; i < NST; i++) begin : g_dabble
    localparam int STEPS = (i == NST - 1) ? VALUE_BITS - BITS_PER_STAGE * (NST - 1)
                                          : BITS_PER_STAGE;
    sbda_dabble #(
      .VALUE_BITS(VALUE_BITS),
      .DIGITS    (DIGITS),
      .STEPS     (STEPS)
    ) u_dabble (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (vld[i]),
      .in_ready (rdy[i]),
      .in_neg   (neg[i]),
      .in_mag   (mag[i]),
      .in_bcd   (bcd[i]),
      .out_valid(vld[i+1]),
      .out_ready(rdy[i+1]),
      .out_neg  (neg[i+1]),
      .out_mag  (mag[i+1]),
      .out_bcd  (bcd[i+1])
    );
  end

  sbda_emit #(
    .DIGITS(DIGITS)
  ) u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (vld[NST]),
    .in_ready (rdy[NST]),
    .in_neg   (neg[NST]),
    .in_bcd   (bcd[NST]),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_char (character),
    .out_last (out_tlast)
  );

  assign out_tdata = {2'b00, character};

  `SBDA_ASSERT_IMP(a_minus_not_last, out_tvalid && character == ASCII_MINUS, !out_tlast)
  `SBDA_ASSERT_NXT(a_digit_after_minus,
    out_tvalid && out_tready && character == ASCII_MINUS,
    out_tvalid && character != ASCII_MINUS)
  `SBDA_ASSERT_IMP(a_char_range, out_tvalid,
    character == ASCII_MINUS || (character >= ASCII_ZERO && character <= ASCII_NINE))

endmodule

`default_nettype wire
